>>> rtl/lafm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and saturating arithmetic helpers for the
// aerodynamic force and moment pipeline. No dependencies.
package lafm_pkg;

	// Saturation bound of every intermediate
	localparam logic signed [63:0] LIM   = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] LIM65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;

	// Nondimensional rate gains (chord/2 and span/2, scaled by 2^24)
	localparam logic signed [26:0] KCH = 27'sd44040192;
	localparam logic signed [28:0] KBH = 29'sd251658240;

	// Stability derivatives, Q.32
	localparam logic signed [63:0] CZ0  = -64'sd510027366;
	localparam logic signed [63:0] CZA  = -64'sd20392826414;
	localparam logic signed [63:0] CZAT = -64'sd93993888246661;
	localparam logic signed [63:0] CZQ  = -64'sd11776667182;
	localparam logic signed [63:0] CM0  = 64'sd411887364;
	localparam logic signed [63:0] CMA  = -64'sd4394106738;
	localparam logic signed [63:0] CMAT = -64'sd362044269;
	localparam logic signed [63:0] CMQ  = -64'sd27263170547;
	localparam logic signed [63:0] CX0  = -64'sd136343737;
	localparam logic signed [63:0] KIND = 64'sd399045541;
	localparam logic signed [63:0] CLB  = -64'sd457611157;
	localparam logic signed [63:0] CLP  = -64'sd2020352616;
	localparam logic signed [63:0] CLR  = 64'sd715112055;
	localparam logic signed [63:0] CYB  = -64'sd1245784470;
	localparam logic signed [63:0] CYR  = 64'sd2047909;
	localparam logic signed [63:0] CNB  = 64'sd394999123;
	localparam logic signed [63:0] CNP  = -64'sd296782240;
	localparam logic signed [63:0] CNR  = -64'sd399431959;

	// Small scale factors: span, four times the chord and twice the wing area
	localparam logic [8:0] K_SPAN  = 9'd30;
	localparam logic [8:0] K_CHORD = 9'd21;
	localparam logic [8:0] K_AREA  = 9'd315;

	// Divider: quotient bits, one per stage, plus entry and exit registers
	localparam int DIV_BITS = 62;
	localparam int DIV_LAT  = DIV_BITS + 2;

	// Flight state carried alongside the divider
	typedef struct packed {
		logic signed [31:0] al;
		logic signed [31:0] be;
		logic signed [31:0] sa;
		logic signed [31:0] ca;
		logic [31:0]        u;
		logic [31:0]        d;
	} in_ctx_t;

	// State carried after the divider
	typedef struct packed {
		logic               flag;
		logic signed [31:0] sa;
		logic signed [31:0] ca;
	} post_ctx_t;

	function automatic logic [63:0] magn(input logic signed [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	function automatic logic signed [63:0] sx32(input logic [31:0] v);
		return $signed({{32{v[31]}}, v});
	endfunction

	// Shift a product magnitude, clip to the bound, restore the sign
	function automatic logic signed [63:0] satsh(input logic [127:0] mag, input logic neg,
			input int unsigned sh);
		logic [127:0] s;
		logic [63:0]  m;
		s = mag >> sh;
		m = (s > {64'd0, LIM}) ? LIM : s[63:0];
		return neg ? -$signed(m) : $signed(m);
	endfunction

	// Saturating add
	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > LIM65)
			return LIM;
		else if (s < -LIM65)
			return -LIM;
		else
			return s[63:0];
	endfunction

	// Right shift truncating toward zero
	function automatic logic signed [63:0] tzsh(input logic signed [63:0] p, input int unsigned sh);
		logic [63:0] r;
		r = magn(p) >> sh;
		return p[63] ? -$signed(r) : $signed(r);
	endfunction

	// Product with a small positive constant, shifted and saturated
	function automatic logic signed [63:0] cmul(input logic signed [63:0] v, input logic [8:0] k,
			input int unsigned sh);
		logic [72:0] pr;
		logic [63:0] m;
		pr = (73'(magn(v)) * 73'(k)) >> sh;
		m = (pr > 73'(LIM)) ? LIM : pr[63:0];
		return v[63] ? -$signed(m) : $signed(m);
	endfunction

	// Clip to the signed 32-bit output range
	function automatic logic [31:0] out32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		else if (v < -64'sd2147483648)
			return 32'h8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

>>> rtl/lafm_mul.sv
`timescale 1ns / 1ps
// Pipelined exact 64 x 64 magnitude multiplier built from four 32 x 32 partials.
// Depends on lafm_pkg.
module lafm_mul import lafm_pkg::*; (
	input  logic               clk,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic [127:0]       mag,
	output logic               neg
);

	logic [63:0]  am_s1, bm_s1;
	logic         neg_s1, neg_s2, neg_s3;
	logic [63:0]  ll_s2, lh_s2, hl_s2, hh_s2;
	logic [127:0] mag_s3;

	// stage 1: magnitudes and sign
	always_ff @(posedge clk) begin
		am_s1  <= magn(a);
		bm_s1  <= magn(b);
		neg_s1 <= a[63] ^ b[63];
	end

	// stage 2: partial products
	always_ff @(posedge clk) begin
		ll_s2  <= 64'(am_s1[31:0])  * 64'(bm_s1[31:0]);
		lh_s2  <= 64'(am_s1[31:0])  * 64'(bm_s1[63:32]);
		hl_s2  <= 64'(am_s1[63:32]) * 64'(bm_s1[31:0]);
		hh_s2  <= 64'(am_s1[63:32]) * 64'(bm_s1[63:32]);
		neg_s2 <= neg_s1;
	end

	// stage 3: recombine
	always_ff @(posedge clk) begin
		mag_s3 <= {hh_s2, ll_s2} + {32'd0, lh_s2, 32'd0} + {32'd0, hl_s2, 32'd0};
		neg_s3 <= neg_s2;
	end

	assign mag = mag_s3;
	assign neg = neg_s3;

endmodule

>>> rtl/lafm_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, quotient truncated
// toward zero. Depends on lafm_pkg.
module lafm_div import lafm_pkg::*; (
	input  logic               clk,
	input  logic signed [63:0] num,
	input  logic [31:0]        den,
	output logic signed [63:0] quo
);

	logic [63:0]          nmag;
	logic [DIV_BITS-1:0]  nq_s  [0:DIV_BITS];
	logic [31:0]          rem_s [0:DIV_BITS];
	logic [31:0]          den_s [0:DIV_BITS];
	logic                 neg_s [0:DIV_BITS];
	logic signed [63:0]   quo_q;

	assign nmag = magn(num);

	// entry: magnitude and sign of the numerator
	always_ff @(posedge clk) begin
		nq_s[0]  <= nmag[DIV_BITS-1:0];
		rem_s[0] <= '0;
		den_s[0] <= den;
		neg_s[0] <= num[63];
	end

	// one trial subtraction per stage; numerator bits shift out, quotient bits in
	for (genvar k = 1; k <= DIV_BITS; k++) begin : g_stage
		logic [32:0] trial, diff;
		logic        ge;
		assign trial = {rem_s[k-1], nq_s[k-1][DIV_BITS-1]};
		assign diff  = trial - {1'b0, den_s[k-1]};
		assign ge    = trial >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[31:0] : trial[31:0];
			nq_s[k]  <= {nq_s[k-1][DIV_BITS-2:0], ge};
			den_s[k] <= den_s[k-1];
			neg_s[k] <= neg_s[k-1];
		end
	end

	// exit: restore sign
	always_ff @(posedge clk) begin
		if (neg_s[DIV_BITS])
			quo_q <= -$signed({{(64-DIV_BITS){1'b0}}, nq_s[DIV_BITS]});
		else
			quo_q <= $signed({{(64-DIV_BITS){1'b0}}, nq_s[DIV_BITS]});
	end

	assign quo = quo_q;

endmodule

>>> rtl/linear_aero_force_moment.sv
`timescale 1ns / 1ps
// Linear stability-derivative aerodynamic force and moment pipeline, top level.
// Depends on lafm_pkg, lafm_mul and lafm_div.
//
// One flight state is taken on every clock edge at which start is high; busy
// is never raised. Each state yields one result, marked by a one-cycle done
// strobe, in order. The path runs through the four parallel 62-stage
// divisions by airspeed and then the chain of multipliers (lift, induced drag
// square and factor, final scaling by dynamic pressure). The receiver cannot
// stall the pipeline.
// A zero airspeed drops the rate terms and raises zero_speed_flag.
module linear_aero_force_moment import lafm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] roll_rate,
	input  logic signed [31:0] pitch_rate,
	input  logic signed [31:0] yaw_rate,
	input  logic signed [31:0] attack_angle,
	input  logic signed [31:0] attack_angle_rate,
	input  logic signed [31:0] sideslip_angle,
	input  logic signed [31:0] sin_attack,
	input  logic signed [31:0] cos_attack,
	input  logic [31:0]        airspeed,
	input  logic [31:0]        air_density,
	output logic               done,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic signed [31:0] moment_roll,
	output logic signed [31:0] moment_pitch,
	output logic signed [31:0] moment_yaw,
	output logic               zero_speed_flag
);

	// multiplier slots
	localparam int NMUL   = 28;
	localparam int M_ZA   = 0;
	localparam int M_ZAT  = 1;
	localparam int M_ZQ   = 2;
	localparam int M_MA   = 3;
	localparam int M_MAT  = 4;
	localparam int M_MQ   = 5;
	localparam int M_LB   = 6;
	localparam int M_LP   = 7;
	localparam int M_LR   = 8;
	localparam int M_YB   = 9;
	localparam int M_YR   = 10;
	localparam int M_NB   = 11;
	localparam int M_NP   = 12;
	localparam int M_NR   = 13;
	localparam int M_QD   = 14;
	localparam int M_ZZ   = 15;
	localparam int M_ZK   = 16;
	localparam int M_CZSA = 17;
	localparam int M_RCA  = 18;
	localparam int M_RSA  = 19;
	localparam int M_YSA  = 20;
	localparam int M_YCA  = 21;
	localparam int M_FX   = 22;
	localparam int M_FY   = 23;
	localparam int M_FZ   = 24;
	localparam int M_ML   = 25;
	localparam int M_MP   = 26;
	localparam int M_MY   = 27;

	// ---------------- front end ----------------
	logic               v_s1, v_s2, v_s3;
	in_ctx_t            ctx_s1, ctx_s2, ctx_s3;
	logic signed [63:0] rp_ca_s1, rr_sa_s1, rp_sa_s1, rr_ca_s1;
	logic signed [58:0] nad_s1, nrq_s1, nad_s2, nrq_s2;
	logic signed [34:0] p24_s2, r24_s2;
	logic signed [63:0] nad_s3, nrq_s3, nump_s3, numr_s3;

	assign busy = 1'b0;

	// front valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: rate rotation products and alpha/pitch numerators
	always_ff @(posedge clk) begin
		rp_ca_s1 <= 64'(roll_rate) * 64'(cos_attack);
		rr_sa_s1 <= 64'(yaw_rate) * 64'(sin_attack);
		rp_sa_s1 <= 64'(roll_rate) * 64'(sin_attack);
		rr_ca_s1 <= 64'(yaw_rate) * 64'(cos_attack);
		nad_s1   <= 59'(attack_angle_rate) * 59'(KCH);
		nrq_s1   <= 59'(pitch_rate) * 59'(KCH);
		ctx_s1   <= '{al: attack_angle, be: sideslip_angle, sa: sin_attack, ca: cos_attack,
			u: airspeed, d: air_density};
	end

	// stage 2: wind-axis roll and yaw rates, Q8.24
	always_ff @(posedge clk) begin
		p24_s2 <= 35'(tzsh(rp_ca_s1, 30)) + 35'(tzsh(rr_sa_s1, 30));
		r24_s2 <= 35'(tzsh(rr_ca_s1, 30)) - 35'(tzsh(rp_sa_s1, 30));
		nad_s2 <= nad_s1;
		nrq_s2 <= nrq_s1;
		ctx_s2 <= ctx_s1;
	end

	// stage 3: roll and yaw numerators
	always_ff @(posedge clk) begin
		nump_s3 <= 64'(p24_s2) * 64'(KBH);
		numr_s3 <= 64'(r24_s2) * 64'(KBH);
		nad_s3  <= 64'(nad_s2);
		nrq_s3  <= 64'(nrq_s2);
		ctx_s3  <= ctx_s2;
	end

	// ---------------- division by airspeed ----------------
	logic signed [63:0] ah_q0, qh_q0, ph_q0, rh_q0;

	lafm_div u_div_ah (.clk(clk), .num(nad_s3),  .den(ctx_s3.u), .quo(ah_q0));
	lafm_div u_div_qh (.clk(clk), .num(nrq_s3),  .den(ctx_s3.u), .quo(qh_q0));
	lafm_div u_div_ph (.clk(clk), .num(nump_s3), .den(ctx_s3.u), .quo(ph_q0));
	lafm_div u_div_rh (.clk(clk), .num(numr_s3), .den(ctx_s3.u), .quo(rh_q0));

	in_ctx_t            dctx_s [0:DIV_LAT-1];
	logic [DIV_LAT-1:0] dv_s;

	// state travelling beside the divider
	always_ff @(posedge clk) begin
		dctx_s[0] <= ctx_s3;
		for (int i = 1; i < DIV_LAT; i++)
			dctx_s[i] <= dctx_s[i-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_s <= '0;
		else
			dv_s <= {dv_s[DIV_LAT-2:0], v_s3};
	end

	// ---------------- back end (stages count from the quotient register) ----
	in_ctx_t            c0;
	logic               flag0;
	logic signed [63:0] al0, be0, ah0, qh0, ph0, rh0;

	assign c0    = dctx_s[DIV_LAT-1];
	assign flag0 = (c0.u == 32'd0);
	assign al0   = $signed({{24{c0.al[31]}}, c0.al, 8'h00});
	assign be0   = $signed({{24{c0.be[31]}}, c0.be, 8'h00});
	assign ah0   = flag0 ? '0 : ah_q0;
	assign qh0   = flag0 ? '0 : qh_q0;
	assign ph0   = flag0 ? '0 : ph_q0;
	assign rh0   = flag0 ? '0 : rh_q0;

	post_ctx_t          pc_s [1:17];
	logic [17:1]        pv_s;
	logic [63:0]        uu_s1;
	logic [31:0]        d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pv_s <= '0;
		else
			pv_s <= {pv_s[16:1], dv_s[DIV_LAT-1]};
	end

	// context and dynamic pressure operands
	always_ff @(posedge clk) begin
		pc_s[1] <= '{flag: flag0, sa: c0.sa, ca: c0.ca};
		for (int i = 2; i <= 17; i++)
			pc_s[i] <= pc_s[i-1];
		uu_s1 <= 64'(c0.u) * 64'(c0.u);
		d_s1  <= c0.d;
	end

	// multiplier bank
	logic signed [63:0] ma [NMUL];
	logic signed [63:0] mb [NMUL];
	logic [127:0]       mm [NMUL];
	logic               mn [NMUL];

	for (genvar g = 0; g < NMUL; g++) begin : g_mul
		lafm_mul u_mul (.clk(clk), .a(ma[g]), .b(mb[g]), .mag(mm[g]), .neg(mn[g]));
	end

	logic signed [63:0] za_s4, zat_s4, zq_s4, ma_s4, mat_s4, mq_s4;
	logic signed [63:0] lb_s4, lp_s4, lr_s4, yb_s4, yr_s4, nb_s4, np_s4, nr_s4;
	logic signed [63:0] czp_s5, cmp_s5, clp_s5, cy_s5, cnp_s5;
	logic signed [63:0] zq_s5, mq_s5, lr_s5, nr_s5, q47_s5;
	logic signed [63:0] cm_s6, cl_s6, cn_s6;
	logic signed [63:0] cz_s [6:13];
	logic signed [63:0] cy_s [6:13];
	logic signed [63:0] qds_s [6:13];
	logic signed [63:0] pt_s [7:13];
	logic signed [63:0] zz_s8;
	logic signed [63:0] czsa_s [10:12];
	logic signed [63:0] rca_s10, rsa_s10, ysa_s10, yca_s10;
	logic signed [63:0] rs_s11, ys_s11;
	logic signed [63:0] rt_s [12:13];
	logic signed [63:0] yt_s [12:13];
	logic signed [63:0] zk_s12;
	logic signed [63:0] cx_s13;
	logic [31:0]        fx_s17, fy_s17, fz_s17, ml_s17, mp_s17, my_s17;

	// operand routing for each multiplier
	always_comb begin
		ma[M_ZA]   = CZA;        mb[M_ZA]   = al0;
		ma[M_ZAT]  = CZAT;       mb[M_ZAT]  = ah0;
		ma[M_ZQ]   = CZQ;        mb[M_ZQ]   = qh0;
		ma[M_MA]   = CMA;        mb[M_MA]   = al0;
		ma[M_MAT]  = CMAT;       mb[M_MAT]  = ah0;
		ma[M_MQ]   = CMQ;        mb[M_MQ]   = qh0;
		ma[M_LB]   = CLB;        mb[M_LB]   = be0;
		ma[M_LP]   = CLP;        mb[M_LP]   = ph0;
		ma[M_LR]   = CLR;        mb[M_LR]   = rh0;
		ma[M_YB]   = CYB;        mb[M_YB]   = be0;
		ma[M_YR]   = CYR;        mb[M_YR]   = rh0;
		ma[M_NB]   = CNB;        mb[M_NB]   = be0;
		ma[M_NP]   = CNP;        mb[M_NP]   = ph0;
		ma[M_NR]   = CNR;        mb[M_NR]   = rh0;
		ma[M_QD]   = $signed({32'd0, d_s1});
		mb[M_QD]   = $signed({2'b00, uu_s1[63:2]});
		ma[M_ZZ]   = za_s4;      mb[M_ZZ]   = za_s4;
		ma[M_ZK]   = zz_s8;      mb[M_ZK]   = KIND;
		ma[M_CZSA] = cz_s[6];    mb[M_CZSA] = sx32(pc_s[6].sa);
		ma[M_RCA]  = cl_s6;      mb[M_RCA]  = sx32(pc_s[6].ca);
		ma[M_RSA]  = cn_s6;      mb[M_RSA]  = sx32(pc_s[6].sa);
		ma[M_YSA]  = cl_s6;      mb[M_YSA]  = sx32(pc_s[6].sa);
		ma[M_YCA]  = cn_s6;      mb[M_YCA]  = sx32(pc_s[6].ca);
		ma[M_FX]   = cx_s13;     mb[M_FX]   = qds_s[13];
		ma[M_FY]   = cy_s[13];   mb[M_FY]   = qds_s[13];
		ma[M_FZ]   = cz_s[13];   mb[M_FZ]   = qds_s[13];
		ma[M_ML]   = rt_s[13];   mb[M_ML]   = qds_s[13];
		ma[M_MP]   = pt_s[13];   mb[M_MP]   = qds_s[13];
		ma[M_MY]   = yt_s[13];   mb[M_MY]   = qds_s[13];
	end

	// stage 4: derivative terms
	always_ff @(posedge clk) begin
		za_s4  <= satsh(mm[M_ZA],  mn[M_ZA],  32);
		zat_s4 <= satsh(mm[M_ZAT], mn[M_ZAT], 32);
		zq_s4  <= satsh(mm[M_ZQ],  mn[M_ZQ],  32);
		ma_s4  <= satsh(mm[M_MA],  mn[M_MA],  32);
		mat_s4 <= satsh(mm[M_MAT], mn[M_MAT], 32);
		mq_s4  <= satsh(mm[M_MQ],  mn[M_MQ],  32);
		lb_s4  <= satsh(mm[M_LB],  mn[M_LB],  32);
		lp_s4  <= satsh(mm[M_LP],  mn[M_LP],  32);
		lr_s4  <= satsh(mm[M_LR],  mn[M_LR],  32);
		yb_s4  <= satsh(mm[M_YB],  mn[M_YB],  32);
		yr_s4  <= satsh(mm[M_YR],  mn[M_YR],  32);
		nb_s4  <= satsh(mm[M_NB],  mn[M_NB],  32);
		np_s4  <= satsh(mm[M_NP],  mn[M_NP],  32);
		nr_s4  <= satsh(mm[M_NR],  mn[M_NR],  32);
	end

	// stage 5: first partial sums, dynamic pressure in Q.16
	always_ff @(posedge clk) begin
		czp_s5 <= sadd(sadd(CZ0, za_s4), zat_s4);
		cmp_s5 <= sadd(sadd(CM0, ma_s4), mat_s4);
		clp_s5 <= sadd(lb_s4, lp_s4);
		cy_s5  <= sadd(yb_s4, yr_s4);
		cnp_s5 <= sadd(nb_s4, np_s4);
		zq_s5  <= zq_s4;
		mq_s5  <= mq_s4;
		lr_s5  <= lr_s4;
		nr_s5  <= nr_s4;
		q47_s5 <= satsh(mm[M_QD], mn[M_QD], 47);
	end

	// stage 6: coefficients, dynamic pressure times wing area; delays up to the final scaling
	always_ff @(posedge clk) begin
		cz_s[6]  <= sadd(czp_s5, zq_s5);
		cm_s6    <= sadd(cmp_s5, mq_s5);
		cl_s6    <= sadd(clp_s5, lr_s5);
		cn_s6    <= sadd(cnp_s5, nr_s5);
		cy_s[6]  <= cy_s5;
		qds_s[6] <= cmul(q47_s5, K_AREA, 1);
		for (int i = 7; i <= 13; i++) begin
			cz_s[i]  <= cz_s[i-1];
			cy_s[i]  <= cy_s[i-1];
			qds_s[i] <= qds_s[i-1];
		end
	end

	// stage 7: pitching moment times chord, then delayed to the final scaling
	always_ff @(posedge clk) begin
		pt_s[7] <= cmul(cm_s6, K_CHORD, 2);
		for (int i = 8; i <= 13; i++)
			pt_s[i] <= pt_s[i-1];
	end

	// induced drag: square of the alpha lift term, then times the factor
	always_ff @(posedge clk) begin
		zz_s8  <= satsh(mm[M_ZZ], mn[M_ZZ], 32);
		zk_s12 <= satsh(mm[M_ZK], mn[M_ZK], 32);
	end

	// stage 10 to 12: drag rotation term and moment rotation to body axes
	always_ff @(posedge clk) begin
		czsa_s[10] <= satsh(mm[M_CZSA], mn[M_CZSA], 30);
		czsa_s[11] <= czsa_s[10];
		czsa_s[12] <= czsa_s[11];
		rca_s10    <= satsh(mm[M_RCA], mn[M_RCA], 30);
		rsa_s10    <= satsh(mm[M_RSA], mn[M_RSA], 30);
		ysa_s10    <= satsh(mm[M_YSA], mn[M_YSA], 30);
		yca_s10    <= satsh(mm[M_YCA], mn[M_YCA], 30);
		rs_s11     <= sadd(rca_s10, -rsa_s10);
		ys_s11     <= sadd(ysa_s10, yca_s10);
		rt_s[12]   <= cmul(rs_s11, K_SPAN, 0);
		yt_s[12]   <= cmul(ys_s11, K_SPAN, 0);
		rt_s[13]   <= rt_s[12];
		yt_s[13]   <= yt_s[12];
	end

	// stage 13: body x coefficient
	always_ff @(posedge clk) begin
		cx_s13 <= sadd(sadd(CX0, -zk_s12), -czsa_s[12]);
	end

	// stage 17: scale by dynamic pressure and clip to the output format
	always_ff @(posedge clk) begin
		fx_s17 <= out32(satsh(mm[M_FX], mn[M_FX], 40));
		fy_s17 <= out32(satsh(mm[M_FY], mn[M_FY], 40));
		fz_s17 <= out32(satsh(mm[M_FZ], mn[M_FZ], 40));
		ml_s17 <= out32(satsh(mm[M_ML], mn[M_ML], 40));
		mp_s17 <= out32(satsh(mm[M_MP], mn[M_MP], 40));
		my_s17 <= out32(satsh(mm[M_MY], mn[M_MY], 40));
	end

	assign done            = pv_s[17];
	assign zero_speed_flag = pc_s[17].flag;
	assign force_x         = $signed(fx_s17);
	assign force_y         = $signed(fy_s17);
	assign force_z         = $signed(fz_s17);
	assign moment_roll     = $signed(ml_s17);
	assign moment_pitch    = $signed(mp_s17);
	assign moment_yaw      = $signed(my_s17);

endmodule
